// ===== src/mei_pkg.sv =====
// Shared constants for the Mandelbrot escape iterator.
// No dependencies; used by every module of the block by scoped name.
package mei_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int COUNT_BITS_DEF = 14;
    localparam int PT_W           = 32;
    localparam int PEAK_FACTOR    = 200;
    localparam int PEAK_START     = 5;
    localparam int PEAK_LIM_EXTRA = 8;
    localparam int LIMIT_RESET    = 250;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = 1;

endpackage

// ===== src/mei_front.sv =====
// Front end: input acceptance and a two-entry point queue.
// Depends on mei_pkg.
module mei_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2*mei_pkg::PT_W-1:0]    in_data,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [2*mei_pkg::PT_W-1:0]    q_data
);

    localparam int DW = 2 * mei_pkg::PT_W;
    localparam int CW = mei_pkg::QPTR_W + 1;

    logic [DW-1:0]                 mem_reg [mei_pkg::QDEPTH];
    logic [mei_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mei_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic                          push, pop;

    assign in_ready = (count_reg != CW'(mei_pkg::QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== src/mei_mul_unit.sv =====
// Shared unsigned multiplier: four half-width partial products, accumulated.
// Depends on mei_pkg for its parameter default; no submodules.
module mei_mul_unit
#(
    parameter int MAG_W = mei_pkg::COUNT_BITS_DEF + mei_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_W-1:0]   a,
    input  logic [MAG_W-1:0]   b,
    output logic               done,
    output logic [2*MAG_W-1:0] product
);

    localparam int HW = (MAG_W + 1) / 2;
    localparam int PW = 2 * MAG_W;
    localparam int XW = 4 * HW;

    logic [MAG_W-1:0]  a_reg, b_reg;
    logic              issue_reg, issue_next;
    logic [1:0]        step_reg, step_next;
    logic              pp_vld_reg, last_reg, done_reg;
    logic [2*HW-1:0]   pp_reg;
    logic [1:0]        sh_reg;
    logic [PW-1:0]     acc_reg;
    logic [HW-1:0]     a_lo, a_hi, b_lo, b_hi, op_a, op_b;
    logic [2*HW-1:0]   pp_next;
    logic [XW-1:0]     pp_ext, pp_sh;

    assign a_lo    = HW'(a_reg);
    assign a_hi    = HW'(a_reg >> HW);
    assign b_lo    = HW'(b_reg);
    assign b_hi    = HW'(b_reg >> HW);
    assign op_a    = step_reg[1] ? a_hi : a_lo;
    assign op_b    = step_reg[0] ? b_hi : b_lo;
    assign pp_next = (2*HW)'(op_a) * (2*HW)'(op_b);
    assign pp_ext  = XW'(pp_reg);

    always_comb
    begin
        unique case (sh_reg)
            2'd1:    pp_sh = pp_ext << HW;
            2'd2:    pp_sh = pp_ext << (2 * HW);
            default: pp_sh = pp_ext;
        endcase
    end

    always_comb
    begin
        issue_next = issue_reg;
        step_next  = step_reg;
        if (start)
        begin
            issue_next = 1'b1;
            step_next  = '0;
        end
        else if (issue_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg == 2'd3)
            begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            step_reg   <= '0;
            pp_vld_reg <= 1'b0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            issue_reg  <= issue_next;
            step_reg   <= step_next;
            pp_vld_reg <= issue_reg && !start;
            last_reg   <= (step_reg == 2'd3);
            done_reg   <= pp_vld_reg && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_reg + PW'(pp_sh);
        end
        pp_reg <= pp_next;
        sh_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== src/mei_core.sv =====
// Back end: escape-time sequencer for one point at a time.
// Depends on mei_pkg and mei_mul_unit.
module mei_core
#(
    parameter int FRAC_BITS  = mei_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = mei_pkg::COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [COUNT_BITS-1:0]        limit,
    input  logic                         pt_valid,
    output logic                         pt_ready,
    input  logic [2*mei_pkg::PT_W-1:0]   pt_data,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [COUNT_BITS-1:0]        res_count,
    output logic                         res_bounded
);

    localparam int MW  = COUNT_BITS + FRAC_BITS;
    localparam int PW  = 2 * MW;
    localparam int NW  = PW - FRAC_BITS + 3;
    localparam int PLW = COUNT_BITS + mei_pkg::PEAK_LIM_EXTRA;
    localparam int C2  = 2 * COUNT_BITS;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_INIT = 11'b00000000010,
        S_ADD1 = 11'b00000000100,
        S_ADD2 = 11'b00000001000,
        S_CHK  = 11'b00000010000,
        S_MRR  = 11'b00000100000,
        S_MII  = 11'b00001000000,
        S_MRI  = 11'b00010000000,
        S_MAG  = 11'b00100000000,
        S_MCHK = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    wait_reg, wait_next;

    logic [mei_pkg::PT_W-1:0] cx_reg, cy_reg;
    logic [C2-1:0]           lim_sq_reg;
    logic [MW-1:0]           re_mag_reg, im_mag_reg;
    logic                    re_neg_reg, im_neg_reg;
    logic [PW-1:0]           rr_reg, ii_reg, ri_reg;
    logic [NW-1:0]           t_re_reg, nr_reg, ni_reg;
    logic [PW:0]             ri_s_reg, mag_reg, peak_reg;
    logic [COUNT_BITS-1:0]   ix_reg, cnt_reg;
    logic [PLW-1:0]          peak_lim_reg;
    logic                    bnd_reg;

    logic                    mul_start, mul_done;
    logic [MW-1:0]           mul_a, mul_b;
    logic [PW-1:0]           mul_p;

    logic [NW-1:0]           rr_sh, ii_sh, cx_ext, cy_ext, ri_sh;
    logic [NW-1:0]           nr_mag, ni_mag, lim_ext;
    logic                    comp_esc;
    logic [PW:0]             limsq_full;
    logic                    mag_esc, peak_upd, cutoff, capped;
    logic [COUNT_BITS-1:0]   ix_new;
    logic [PW:0]             ri_ext;

    mei_mul_unit #(.MAG_W(MW)) u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign rr_sh   = NW'(rr_reg >> FRAC_BITS);
    assign ii_sh   = NW'(ii_reg >> FRAC_BITS);
    assign cx_ext  = NW'($signed(cx_reg));
    assign cy_ext  = NW'($signed(cy_reg));
    assign ri_sh   = NW'($signed(ri_s_reg) >>> (FRAC_BITS - 1));
    assign ri_ext  = {1'b0, ri_reg};
    assign nr_mag  = nr_reg[NW-1] ? (~nr_reg) + NW'(1) : nr_reg;
    assign ni_mag  = ni_reg[NW-1] ? (~ni_reg) + NW'(1) : ni_reg;
    assign lim_ext = NW'({limit, {FRAC_BITS{1'b0}}});
    assign comp_esc = (nr_mag > lim_ext) || (ni_mag > lim_ext);

    assign limsq_full = (PW+1)'({lim_sq_reg, {(2*FRAC_BITS){1'b0}}});
    assign mag_esc    = (mag_reg > limsq_full);
    assign peak_upd   = (mag_reg > peak_reg);
    assign ix_new     = ix_reg + 1'b1;
    assign cutoff     = !peak_upd && (PLW'(ix_new) > peak_lim_reg);
    assign capped     = (ix_new >= limit);

    assign pt_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res_count   = cnt_reg;
    assign res_bounded = bnd_reg;

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = re_mag_reg;
        mul_b     = re_mag_reg;
        unique case (state_reg)
            S_MRR:
            begin
                mul_start = !wait_reg;
            end
            S_MII:
            begin
                mul_start = !wait_reg;
                mul_a     = im_mag_reg;
                mul_b     = im_mag_reg;
            end
            S_MRI:
            begin
                mul_start = !wait_reg;
                mul_b     = im_mag_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pt_valid)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = (limit == '0) ? S_DONE : S_ADD1;
            end
            S_ADD1: state_next = S_ADD2;
            S_ADD2: state_next = S_CHK;
            S_CHK:
            begin
                state_next = comp_esc ? S_DONE : S_MRR;
            end
            S_MRR, S_MII, S_MRI:
            begin
                if (!wait_reg)
                begin
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    priority case (1'b1)
                        state_reg == S_MRR: state_next = S_MII;
                        state_reg == S_MII: state_next = S_MRI;
                        default:            state_next = S_MAG;
                    endcase
                end
            end
            S_MAG:  state_next = S_MCHK;
            S_MCHK:
            begin
                state_next = (mag_esc || cutoff || capped) ? S_DONE : S_ADD1;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cx_reg <= pt_data[mei_pkg::PT_W-1:0];
                cy_reg <= pt_data[2*mei_pkg::PT_W-1:mei_pkg::PT_W];
            end
            S_INIT:
            begin
                lim_sq_reg   <= C2'(limit) * C2'(limit);
                re_mag_reg   <= '0;
                im_mag_reg   <= '0;
                re_neg_reg   <= 1'b0;
                im_neg_reg   <= 1'b0;
                rr_reg       <= '0;
                ii_reg       <= '0;
                ri_reg       <= '0;
                ix_reg       <= '0;
                peak_reg     <= '0;
                peak_lim_reg <= PLW'(mei_pkg::PEAK_START * mei_pkg::PEAK_FACTOR);
                cnt_reg      <= '0;
                bnd_reg      <= 1'b1;
            end
            S_ADD1:
            begin
                t_re_reg <= rr_sh - ii_sh;
                ri_s_reg <= (re_neg_reg ^ im_neg_reg) ? (~ri_ext) + (PW+1)'(1) : ri_ext;
            end
            S_ADD2:
            begin
                nr_reg <= t_re_reg + cx_ext;
                ni_reg <= ri_sh + cy_ext;
            end
            S_CHK:
            begin
                re_mag_reg <= MW'(nr_mag);
                im_mag_reg <= MW'(ni_mag);
                re_neg_reg <= nr_reg[NW-1];
                im_neg_reg <= ni_reg[NW-1];
                cnt_reg    <= ix_reg;
                bnd_reg    <= !comp_esc;
            end
            S_MRR:
            begin
                if (mul_done)
                begin
                    rr_reg <= mul_p;
                end
            end
            S_MII:
            begin
                if (mul_done)
                begin
                    ii_reg <= mul_p;
                end
            end
            S_MRI:
            begin
                if (mul_done)
                begin
                    ri_reg <= mul_p;
                end
            end
            S_MAG:
            begin
                mag_reg <= (PW+1)'(rr_reg) + (PW+1)'(ii_reg);
            end
            S_MCHK:
            begin
                if (mag_esc)
                begin
                    cnt_reg <= ix_reg;
                    bnd_reg <= 1'b0;
                end
                else
                begin
                    ix_reg  <= ix_new;
                    cnt_reg <= '0;
                    bnd_reg <= 1'b1;
                    if (peak_upd)
                    begin
                        peak_reg     <= mag_reg;
                        peak_lim_reg <= PLW'(ix_new) * PLW'(mei_pkg::PEAK_FACTOR);
                    end
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

// ===== src/mandelbrot_escape_iterator_unit.sv =====
// Top level of the Mandelbrot escape iterator: config register, front queue,
// iteration core and output register. Depends on mei_pkg, mei_front, mei_core.
//
//  Channel   Dir  Signals                          Contents
//  s_axis    in   tvalid tready tdata[63:0]        cx [31:0], cy [63:32]
//  m_axis    out  tvalid tready tdata tuser        escape_count, bounded
//  cfg       in   cfg_we cfg_wdata                 limit
//
//  Each item is accepted, set up and handed off (the hand-off waits while the output
//  register is full), with each iteration in between; an iteration that ends on
//  the component check skips the shared multiplier's three passes.
//  Two items queue ahead of the core; a finished result waits in the output
//  register while the core starts on the next item.
//  Reset is asynchronous, active low; limit resets to 250.
module mandelbrot_escape_iterator_unit
#(
    parameter int FRAC_BITS  = mei_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = mei_pkg::COUNT_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*mei_pkg::PT_W-1:0]           s_axis_tdata,  // cx, cy
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((COUNT_BITS+7)/8)*8-1:0]      m_axis_tdata,  // escape_count
    output logic                                 m_axis_tuser,  // bounded
    input  logic                                 cfg_we,
    input  logic [COUNT_BITS-1:0]                cfg_wdata      // limit
);

    localparam int OUT_W = ((COUNT_BITS + 7) / 8) * 8;

    logic [COUNT_BITS-1:0]           limit_reg;
    logic                            q_valid, q_ready;
    logic [2*mei_pkg::PT_W-1:0]      q_data;
    logic                            res_valid, res_ready, res_bounded;
    logic [COUNT_BITS-1:0]           res_count;
    logic                            out_vld_reg;
    logic [COUNT_BITS-1:0]           out_cnt_reg;
    logic                            out_bnd_reg;

    mei_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    mei_core #(.FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (limit_reg),
        .pt_valid    (q_valid),
        .pt_ready    (q_ready),
        .pt_data     (q_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_count   (res_count),
        .res_bounded (res_bounded)
    );

    assign res_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= COUNT_BITS'(mei_pkg::LIMIT_RESET);
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                out_vld_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_cnt_reg <= res_count;
            out_bnd_reg <= res_bounded;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_W'(out_cnt_reg);
    assign m_axis_tuser  = out_bnd_reg;

endmodule
